// ===== design/mont_pkg.sv =====
// ----------------------------------------------------------------------------
// mont_pkg
// Types, codes and sizes shared by the neighbour table search block.
// ----------------------------------------------------------------------------
`default_nettype none

package mont_pkg;

    localparam int MAX_NEIGHBOURS = 16;
    localparam int WEIGHT_BITS    = 16;
    localparam int LABEL_COUNT    = 64;

    // stored weight never holds more than the 16-bit input field
    localparam int W_STORE = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int IDX_W   = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam int CNT_W   = $clog2(MAX_NEIGHBOURS + 1);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    localparam logic [1:0] ADDR_OWN_NODE_ID = 2'd0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  neighbor_id;
        logic [15:0] edge_weight;
        logic [5:0]  status_value;
        logic [63:0] exclude_mask;
        logic [15:0] prior_best_weight;
        logic [7:0]  prior_best_route;
        logic [7:0]  prior_extend_node;
    } in_item_t;

    typedef struct packed {
        logic [15:0] best_weight;
        logic [7:0]  best_route;
        logic [7:0]  extend_node;
        logic        improved;
        logic [1:0]  op_status;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         id;
        logic [W_STORE-1:0] weight;
        logic [5:0]         label;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } tbl_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== design/mont_table.sv =====
// ----------------------------------------------------------------------------
// mont_table
// Neighbour entry store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mont_table (
    input  wire logic              aclk,
    input  wire mont_pkg::tbl_req_t req,
    output mont_pkg::entry_t       rd_data
);

    mont_pkg::entry_t mem_reg [mont_pkg::MAX_NEIGHBOURS];
    mont_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/mont_scan.sv =====
// ----------------------------------------------------------------------------
// mont_scan
// Sequencer and shared compare unit: walks the table one entry a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mont_scan (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [7:0]          own_node_id,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mont_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mont_pkg::out_item_t      m_data,
    output mont_pkg::tbl_req_t       tbl_req,
    input  wire mont_pkg::entry_t    tbl_rd_data
);

    mont_pkg::state_t                state_reg, state_next;
    logic [mont_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [mont_pkg::CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [mont_pkg::IDX_W-1:0]      eval_idx_reg, eval_idx_next;
    logic                            eval_valid_reg, eval_valid_next;
    logic                            found_reg, found_next;
    logic                            improved_reg, improved_next;
    logic [1:0]                      status_reg, status_next;
    mont_pkg::in_item_t              item_reg, item_next;
    logic [15:0]                     best_w_reg, best_w_next;
    logic [7:0]                      best_r_reg, best_r_next;
    logic [7:0]                      best_x_reg, best_x_next;
    logic                            m_valid_reg, m_valid_next;
    mont_pkg::out_item_t             m_data_reg, m_data_next;

    logic        accept;
    logic        match_now;
    logic        excluded;
    logic        issue;
    logic [15:0] entry_w;

    assign s_ready = (state_reg == mont_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign entry_w  = 16'(tbl_rd_data.weight);
    assign excluded = (7'(tbl_rd_data.label) < 7'(mont_pkg::LABEL_COUNT))
                      && item_reg.exclude_mask[tbl_rd_data.label];
    assign match_now = (state_reg == mont_pkg::ST_SCAN) && eval_valid_reg && !found_reg
                       && (item_reg.kind == mont_pkg::KIND_UPDATE)
                       && (tbl_rd_data.id == item_reg.neighbor_id);
    assign issue = (state_reg == mont_pkg::ST_SCAN) && (rd_idx_reg < count_reg)
                   && !found_reg && !match_now;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        eval_idx_next   = eval_idx_reg;
        eval_valid_next = 1'b0;
        found_next      = found_reg;
        improved_next   = improved_reg;
        status_next     = status_reg;
        item_next       = item_reg;
        best_w_next     = best_w_reg;
        best_r_next     = best_r_reg;
        best_x_next     = best_x_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        tbl_req         = '0;

        unique case (state_reg)
            mont_pkg::ST_IDLE: begin
                if (accept) begin
                    item_next     = s_data;
                    best_w_next   = s_data.prior_best_weight;
                    best_r_next   = s_data.prior_best_route;
                    best_x_next   = s_data.prior_extend_node;
                    improved_next = 1'b0;
                    found_next    = 1'b0;
                    rd_idx_next   = '0;
                    status_next   = mont_pkg::STAT_OK;
                    state_next    = mont_pkg::ST_DONE;
                    unique case (s_data.kind)
                        mont_pkg::KIND_ADD: begin
                            if (count_reg < mont_pkg::CNT_W'(mont_pkg::MAX_NEIGHBOURS)) begin
                                tbl_req.wr_en          = 1'b1;
                                tbl_req.wr_addr        = count_reg[mont_pkg::IDX_W-1:0];
                                tbl_req.wr_data.id     = s_data.neighbor_id;
                                tbl_req.wr_data.weight =
                                    mont_pkg::W_STORE'(s_data.edge_weight);
                                tbl_req.wr_data.label  = s_data.status_value;
                                count_next             = count_reg + 1'b1;
                            end else begin
                                status_next = mont_pkg::STAT_FULL;
                            end
                        end
                        mont_pkg::KIND_UPDATE: begin
                            status_next = mont_pkg::STAT_NOT_FOUND;
                            state_next  = mont_pkg::ST_SCAN;
                        end
                        mont_pkg::KIND_SEARCH: begin
                            state_next = mont_pkg::ST_SCAN;
                        end
                        default: begin
                            // unused kind: echo the priors
                            state_next = mont_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            mont_pkg::ST_SCAN: begin
                if (issue) begin
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = rd_idx_reg[mont_pkg::IDX_W-1:0];
                    eval_idx_next   = rd_idx_reg[mont_pkg::IDX_W-1:0];
                    eval_valid_next = 1'b1;
                    rd_idx_next     = rd_idx_reg + 1'b1;
                end
                if (eval_valid_reg && !found_reg) begin
                    if (item_reg.kind == mont_pkg::KIND_SEARCH) begin
                        if (!excluded && (entry_w < best_w_reg)) begin
                            best_w_next   = entry_w;
                            best_r_next   = tbl_rd_data.id;
                            best_x_next   = own_node_id;
                            improved_next = 1'b1;
                        end
                    end else if (match_now) begin
                        // relabel the first matching entry, then stop
                        tbl_req.wr_en         = 1'b1;
                        tbl_req.wr_addr       = eval_idx_reg;
                        tbl_req.wr_data       = tbl_rd_data;
                        tbl_req.wr_data.label = item_reg.status_value;
                        found_next            = 1'b1;
                        status_next           = mont_pkg::STAT_OK;
                    end
                end
                if (!issue && !eval_valid_reg) begin
                    state_next = mont_pkg::ST_DONE;
                end
            end
            mont_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.best_weight = best_w_reg;
                    m_data_next.best_route  = best_r_reg;
                    m_data_next.extend_node = best_x_reg;
                    m_data_next.improved    = improved_reg;
                    m_data_next.op_status   = status_reg;
                    state_next              = mont_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mont_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mont_pkg::ST_IDLE;
            count_reg      <= '0;
            eval_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            improved_reg   <= 1'b0;
            status_reg     <= mont_pkg::STAT_OK;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            eval_valid_reg <= eval_valid_next;
            found_reg      <= found_next;
            improved_reg   <= improved_next;
            status_reg     <= status_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        eval_idx_reg <= eval_idx_next;
        item_reg     <= item_next;
        best_w_reg   <= best_w_next;
        best_r_reg   <= best_r_next;
        best_x_reg   <= best_x_next;
        m_data_reg   <= m_data_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= mont_pkg::CNT_W'(mont_pkg::MAX_NEIGHBOURS))
        else $error("entry count beyond table depth");

    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_req.wr_en |-> (accept && (s_data.kind == mont_pkg::KIND_ADD))
                          || ((state_reg == mont_pkg::ST_SCAN)
                              && (item_reg.kind == mont_pkg::KIND_UPDATE)))
        else $error("table written outside add or label update");

    a_improved_search: assert property (@(posedge aclk) disable iff (!aresetn)
        improved_reg |-> (item_reg.kind == mont_pkg::KIND_SEARCH))
        else $error("improved flag set by a non-search item");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (status_reg == mont_pkg::STAT_OK))
        else $error("label update found but status not ok");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> ($past(state_reg) == mont_pkg::ST_DONE))
        else $error("result loaded outside done state");

endmodule

`default_nettype wire

// ===== design/min_outgoing_edge_neighbour_table.sv =====
// ----------------------------------------------------------------------------
// min_outgoing_edge_neighbour_table
// Neighbour table with label update and minimum outgoing edge search.
// ----------------------------------------------------------------------------
// Sequencing: add and unused kinds go from accept straight to m_valid; search and
//   update first scan the entries (an update stops at its first match), reading
//   one table entry per cycle through a single port. A new item is taken only
//   once the last result is loaded; m_ready stalls hold it back.
// Reset: synchronous, active low; clears the entry count, own_node_id and the
//   handshake state. Table contents stay undefined, no clearing pass needed.
// ----------------------------------------------------------------------------
`default_nettype none

module min_outgoing_edge_neighbour_table (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [1:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // items in
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mont_pkg::in_item_t  s_data,
    // items out
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mont_pkg::out_item_t      m_data
);

    logic [7:0]          own_id_reg;
    mont_pkg::tbl_req_t  tbl_req;
    mont_pkg::entry_t    tbl_rd_data;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg <= '0;
        end else if (psel && penable && pwrite && (paddr == mont_pkg::ADDR_OWN_NODE_ID)) begin
            own_id_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == mont_pkg::ADDR_OWN_NODE_ID) begin
            prdata = 32'(own_id_reg);
        end
    end

    mont_table u_table (
        .aclk    (aclk),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    mont_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .own_node_id (own_id_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .tbl_req     (tbl_req),
        .tbl_rd_data (tbl_rd_data)
    );

endmodule

`default_nettype wire
